// ===== rtl/core/las_pkg.sv =====
`default_nettype none

package las_pkg;

    localparam int SYM_W         = 8;
    localparam int SCORE_W       = 12;
    localparam int TPOS_W        = 16;
    localparam int MATCH_W       = 4;
    localparam int PEN_W         = 5;
    localparam int CFG_W         = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_QUERY_DEF = 256;

    localparam logic [SCORE_W-1:0] SCORE_MAX    = '1;
    localparam logic [MATCH_W-1:0] MATCH_RST    = 4'd3;
    localparam logic [PEN_W-1:0]   MISMATCH_RST = 5'h1E;
    localparam logic [PEN_W-1:0]   GAP_RST      = 5'h1E;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_TARGET = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd2;

    // Control part of a beat as it travels down the cell chain.
    typedef struct packed {
        logic valid;
        logic is_target;
        logic fresh;
        logic store;
        logic last;
        logic overflow;
    } tok_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/las_cell.sv =====
`default_nettype none

module las_cell
    import las_pkg::*;
#(
    parameter int CELL_ID = 0,
    parameter int IDX_W   = 8,
    parameter int QPOS_W  = 9
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [MATCH_W-1:0]        match_score,
    input  logic signed [PEN_W-1:0]   mismatch_score,
    input  logic signed [PEN_W-1:0]   gap_score,
    input  tok_ctrl_t                 up_ctrl,
    input  logic [SYM_W-1:0]          up_symbol,
    input  logic [IDX_W-1:0]          up_index,
    input  logic [TPOS_W-1:0]         up_tpos,
    input  logic [SCORE_W-1:0]        up_score,
    input  logic [SCORE_W-1:0]        up_best_score,
    input  logic [QPOS_W-1:0]         up_best_qpos,
    input  logic [TPOS_W-1:0]         up_best_tpos,
    output tok_ctrl_t                 down_ctrl,
    output logic [SYM_W-1:0]          down_symbol,
    output logic [IDX_W-1:0]          down_index,
    output logic [TPOS_W-1:0]         down_tpos,
    output logic [SCORE_W-1:0]        down_score,
    output logic [SCORE_W-1:0]        down_best_score,
    output logic [QPOS_W-1:0]         down_best_qpos,
    output logic [TPOS_W-1:0]         down_best_tpos
);

    localparam int EXT_W = SCORE_W + 2;
    localparam logic [IDX_W-1:0]  MY_INDEX = IDX_W'(CELL_ID);
    localparam logic [QPOS_W-1:0] MY_QPOS  = QPOS_W'(CELL_ID + 1);

    logic [SYM_W-1:0]   q_reg, q_next;
    logic               loaded_reg, loaded_next;
    logic [SCORE_W-1:0] h_reg, h_next;
    logic [SCORE_W-1:0] diag_reg, diag_next;
    logic [SCORE_W-1:0] lbest_score_reg, lbest_score_next;
    logic [TPOS_W-1:0]  lbest_tpos_reg, lbest_tpos_next;

    tok_ctrl_t          down_ctrl_reg, down_ctrl_next;
    logic [SYM_W-1:0]   down_symbol_reg, down_symbol_next;
    logic [IDX_W-1:0]   down_index_reg, down_index_next;
    logic [TPOS_W-1:0]  down_tpos_reg, down_tpos_next;
    logic [SCORE_W-1:0] down_score_reg, down_score_next;
    logic [SCORE_W-1:0] down_best_score_reg, down_best_score_next;
    logic [QPOS_W-1:0]  down_best_qpos_reg, down_best_qpos_next;
    logic [TPOS_W-1:0]  down_best_tpos_reg, down_best_tpos_next;

    logic                    hit_target;
    logic                    hit_load;
    logic signed [EXT_W-1:0] gap_ext;
    logic signed [EXT_W-1:0] diag_delta;
    logic signed [EXT_W-1:0] d_val;
    logic signed [EXT_W-1:0] u_val;
    logic signed [EXT_W-1:0] l_val;
    logic signed [EXT_W-1:0] h_raw;
    logic [SCORE_W-1:0]      h_cell;
    logic                    local_take;
    logic [SCORE_W-1:0]      cand_score;
    logic [TPOS_W-1:0]       cand_tpos;
    logic                    carry_take;

    always_comb
    begin
        hit_target = up_ctrl.valid && up_ctrl.is_target && loaded_reg;
        hit_load   = up_ctrl.valid && !up_ctrl.is_target;

        gap_ext = $signed({{(EXT_W-PEN_W){gap_score[PEN_W-1]}}, gap_score});
        if (q_reg == up_symbol)
        begin
            diag_delta = $signed({{(EXT_W-MATCH_W){1'b0}}, match_score});
        end
        else
        begin
            diag_delta = $signed({{(EXT_W-PEN_W){mismatch_score[PEN_W-1]}}, mismatch_score});
        end

        d_val = $signed({2'b00, diag_reg}) + diag_delta;
        u_val = $signed({2'b00, up_score}) + gap_ext;
        l_val = $signed({2'b00, h_reg}) + gap_ext;

        h_raw = d_val;
        if (u_val > h_raw)
        begin
            h_raw = u_val;
        end
        if (l_val > h_raw)
        begin
            h_raw = l_val;
        end

        if (h_raw[EXT_W-1])
        begin
            h_cell = '0;
        end
        else if (h_raw > $signed({2'b00, SCORE_MAX}))
        begin
            h_cell = SCORE_MAX;
        end
        else
        begin
            h_cell = h_raw[SCORE_W-1:0];
        end

        // Within one row a later column wins a tie.
        local_take = hit_target && (h_cell != '0) && (h_cell >= lbest_score_reg);
        cand_score = local_take ? h_cell : lbest_score_reg;
        cand_tpos  = local_take ? up_tpos : lbest_tpos_reg;

        // Across rows a later row wins a tie, so this cell beats what came from above on equal.
        carry_take = (cand_score != '0) && (cand_score >= up_best_score);

        down_ctrl_next       = up_ctrl;
        down_symbol_next     = up_symbol;
        down_index_next      = up_index;
        down_tpos_next       = up_tpos;
        down_score_next      = hit_target ? h_cell : '0;
        down_best_score_next = up_best_score;
        down_best_qpos_next  = up_best_qpos;
        down_best_tpos_next  = up_best_tpos;
        if (up_ctrl.is_target && up_ctrl.last && carry_take)
        begin
            down_best_score_next = cand_score;
            down_best_qpos_next  = MY_QPOS;
            down_best_tpos_next  = cand_tpos;
        end

        q_next           = q_reg;
        loaded_next      = loaded_reg;
        h_next           = h_reg;
        diag_next        = diag_reg;
        lbest_score_next = lbest_score_reg;
        lbest_tpos_next  = lbest_tpos_reg;

        if (hit_load)
        begin
            if (up_ctrl.fresh)
            begin
                loaded_next      = 1'b0;
                h_next           = '0;
                diag_next        = '0;
                lbest_score_next = '0;
                lbest_tpos_next  = '0;
            end
            if (up_ctrl.store && (up_index == MY_INDEX))
            begin
                q_next      = up_symbol;
                loaded_next = 1'b1;
            end
        end

        if (hit_target)
        begin
            if (up_ctrl.last)
            begin
                h_next           = '0;
                diag_next        = '0;
                lbest_score_next = '0;
                lbest_tpos_next  = '0;
            end
            else
            begin
                h_next           = h_cell;
                diag_next        = up_score;
                lbest_score_next = cand_score;
                lbest_tpos_next  = cand_tpos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg      <= 1'b0;
            h_reg           <= '0;
            diag_reg        <= '0;
            lbest_score_reg <= '0;
            lbest_tpos_reg  <= '0;
            down_ctrl_reg   <= '0;
        end
        else if (advance)
        begin
            loaded_reg      <= loaded_next;
            h_reg           <= h_next;
            diag_reg        <= diag_next;
            lbest_score_reg <= lbest_score_next;
            lbest_tpos_reg  <= lbest_tpos_next;
            down_ctrl_reg   <= down_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q_reg               <= q_next;
            down_symbol_reg     <= down_symbol_next;
            down_index_reg      <= down_index_next;
            down_tpos_reg       <= down_tpos_next;
            down_score_reg      <= down_score_next;
            down_best_score_reg <= down_best_score_next;
            down_best_qpos_reg  <= down_best_qpos_next;
            down_best_tpos_reg  <= down_best_tpos_next;
        end
    end

    assign down_ctrl       = down_ctrl_reg;
    assign down_symbol     = down_symbol_reg;
    assign down_index      = down_index_reg;
    assign down_tpos       = down_tpos_reg;
    assign down_score      = down_score_reg;
    assign down_best_score = down_best_score_reg;
    assign down_best_qpos  = down_best_qpos_reg;
    assign down_best_tpos  = down_best_tpos_reg;

endmodule

`default_nettype wire

// ===== rtl/core/local_alignment_score.sv =====
// A result leaves through the output register after its last target beat is accepted
// and has walked the whole cell chain, one cell per cycle while the chain advances.
// Throughput: one beat per cycle; input stalls only while a finished result waits in
// the output register and the next result has reached the end of the chain.
// Reset (rst_n low, asynchronous): scores and bests cleared, query closed, config
// back to match 3, mismatch -2, gap -2; stored query symbols are undefined until loaded.
`default_nettype none

module local_alignment_score
    import las_pkg::*;
#(
    parameter int MAX_QUERY = MAX_QUERY_DEF,
    parameter int QPOS_W    = $clog2(MAX_QUERY + 1)
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 cmd,
    input  logic [SYM_W-1:0]     symbol,
    input  logic                 last,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [SCORE_W-1:0]   best_score,
    output logic [QPOS_W-1:0]    best_query_pos,
    output logic [TPOS_W-1:0]    best_target_pos,
    output logic                 truncated
);

    localparam int IDX_W = $clog2(MAX_QUERY);
    localparam int LEN_W = $clog2(MAX_QUERY + 1);

    logic [MATCH_W-1:0] match_reg, match_next;
    logic [PEN_W-1:0]   mismatch_reg, mismatch_next;
    logic [PEN_W-1:0]   gap_reg, gap_next;

    logic [LEN_W-1:0]   qlen_reg, qlen_next;
    logic               closed_reg, closed_next;
    logic               ovf_reg, ovf_next;
    logic [TPOS_W-1:0]  tpos_reg, tpos_next;

    logic               result_valid_reg, result_valid_next;
    logic [SCORE_W-1:0] best_score_reg;
    logic [QPOS_W-1:0]  best_qpos_reg;
    logic [TPOS_W-1:0]  best_tpos_reg;
    logic               truncated_reg;

    logic               advance;
    logic               accept;
    logic               fresh;
    logic [LEN_W-1:0]   len_base;
    logic               ovf_base;
    logic               store;
    logic [TPOS_W-1:0]  tpos_inc;
    logic               tail_result;

    tok_ctrl_t          head_ctrl;
    logic [TPOS_W-1:0]  head_tpos;

    tok_ctrl_t          link_ctrl       [0:MAX_QUERY];
    logic [SYM_W-1:0]   link_symbol     [0:MAX_QUERY];
    logic [IDX_W-1:0]   link_index      [0:MAX_QUERY];
    logic [TPOS_W-1:0]  link_tpos       [0:MAX_QUERY];
    logic [SCORE_W-1:0] link_score      [0:MAX_QUERY];
    logic [SCORE_W-1:0] link_best_score [0:MAX_QUERY];
    logic [QPOS_W-1:0]  link_best_qpos  [0:MAX_QUERY];
    logic [TPOS_W-1:0]  link_best_tpos  [0:MAX_QUERY];

    // The whole chain holds only when a result would land on an occupied, stalled output.
    assign tail_result = link_ctrl[MAX_QUERY].valid && link_ctrl[MAX_QUERY].is_target
                         && link_ctrl[MAX_QUERY].last;
    assign advance     = !(tail_result && result_valid_reg && result_stall);
    assign item_stall  = !advance;
    assign accept      = item_valid && advance;

    always_comb
    begin
        match_next    = match_reg;
        mismatch_next = mismatch_reg;
        gap_next      = gap_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MATCH:    match_next    = cfg_data[MATCH_W-1:0];
                CFG_MISMATCH: mismatch_next = cfg_data[PEN_W-1:0];
                CFG_GAP:      gap_next      = cfg_data[PEN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        fresh    = (cmd == CMD_LOAD) && closed_reg;
        len_base = fresh ? '0 : qlen_reg;
        ovf_base = fresh ? 1'b0 : ovf_reg;
        store    = len_base < LEN_W'(MAX_QUERY);
        tpos_inc = (tpos_reg == '1) ? tpos_reg : tpos_reg + TPOS_W'(1);

        qlen_next   = qlen_reg;
        closed_next = closed_reg;
        ovf_next    = ovf_reg;
        tpos_next   = tpos_reg;
        head_tpos   = tpos_inc;

        if (accept)
        begin
            if (cmd == CMD_LOAD)
            begin
                qlen_next   = store ? len_base + LEN_W'(1) : len_base;
                ovf_next    = ovf_base || !store;
                closed_next = last;
                if (fresh)
                begin
                    tpos_next = '0;
                end
            end
            else
            begin
                closed_next = 1'b1;
                tpos_next   = last ? '0 : tpos_inc;
            end
        end

        head_ctrl.valid     = accept;
        head_ctrl.is_target = (cmd == CMD_TARGET);
        head_ctrl.fresh     = fresh;
        head_ctrl.store     = store;
        head_ctrl.last      = last;
        head_ctrl.overflow  = ovf_reg;
    end

    assign link_ctrl[0]       = head_ctrl;
    assign link_symbol[0]     = symbol;
    assign link_index[0]      = len_base[IDX_W-1:0];
    assign link_tpos[0]       = head_tpos;
    assign link_score[0]      = '0;
    assign link_best_score[0] = '0;
    assign link_best_qpos[0]  = '0;
    assign link_best_tpos[0]  = '0;

    for (genvar k = 0; k < MAX_QUERY; k++)
    begin : g_cell
        las_cell #(
            .CELL_ID (k),
            .IDX_W   (IDX_W),
            .QPOS_W  (QPOS_W)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .advance         (advance),
            .match_score     (match_reg),
            .mismatch_score  (mismatch_reg),
            .gap_score       (gap_reg),
            .up_ctrl         (link_ctrl[k]),
            .up_symbol       (link_symbol[k]),
            .up_index        (link_index[k]),
            .up_tpos         (link_tpos[k]),
            .up_score        (link_score[k]),
            .up_best_score   (link_best_score[k]),
            .up_best_qpos    (link_best_qpos[k]),
            .up_best_tpos    (link_best_tpos[k]),
            .down_ctrl       (link_ctrl[k+1]),
            .down_symbol     (link_symbol[k+1]),
            .down_index      (link_index[k+1]),
            .down_tpos       (link_tpos[k+1]),
            .down_score      (link_score[k+1]),
            .down_best_score (link_best_score[k+1]),
            .down_best_qpos  (link_best_qpos[k+1]),
            .down_best_tpos  (link_best_tpos[k+1])
        );
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance && tail_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg        <= MATCH_RST;
            mismatch_reg     <= MISMATCH_RST;
            gap_reg          <= GAP_RST;
            qlen_reg         <= '0;
            closed_reg       <= 1'b1;
            ovf_reg          <= 1'b0;
            tpos_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            match_reg        <= match_next;
            mismatch_reg     <= mismatch_next;
            gap_reg          <= gap_next;
            qlen_reg         <= qlen_next;
            closed_reg       <= closed_next;
            ovf_reg          <= ovf_next;
            tpos_reg         <= tpos_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail_result)
        begin
            best_score_reg <= link_best_score[MAX_QUERY];
            best_qpos_reg  <= link_best_qpos[MAX_QUERY];
            best_tpos_reg  <= link_best_tpos[MAX_QUERY];
            truncated_reg  <= link_ctrl[MAX_QUERY].overflow;
        end
    end

    assign result_valid    = result_valid_reg;
    assign best_score      = best_score_reg;
    assign best_query_pos  = best_qpos_reg;
    assign best_target_pos = best_tpos_reg;
    assign truncated       = truncated_reg;

    // A positive score always comes with a real cell position, and zero with none.
    a_pos_matches_score: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((best_score == '0) == (best_query_pos == '0)))
        else $error("best position disagrees with best score");

    a_tpos_with_score: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (best_score != '0) |-> (best_target_pos != '0))
        else $error("positive best score without a target position");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled while the output is free");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(best_score)
                                         && $stable(best_target_pos))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import las_pkg::*;

    localparam int QUERY_CAP = MAX_QUERY_DEF;
    localparam int QPOS_BITS = $clog2(QUERY_CAP + 1);
    localparam int TPOS_TOP = 65535;
    localparam int DRAIN_CYCLES = QUERY_CAP + 32;

    typedef struct {
        logic [SCORE_W-1:0]   score;
        logic [QPOS_BITS-1:0] qpos;
        logic [TPOS_W-1:0]    tpos;
        logic                 trunc;
    } alignment_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic                 cmd = 1'b0;
    logic [SYM_W-1:0]     symbol = '0;
    logic                 last = 1'b0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [SCORE_W-1:0]   best_score;
    logic [QPOS_BITS-1:0] best_query_pos;
    logic [TPOS_W-1:0]    best_target_pos;
    logic                 truncated;

    local_alignment_score #(
        .MAX_QUERY(QUERY_CAP)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .cmd            (cmd),
        .symbol         (symbol),
        .last           (last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .best_score     (best_score),
        .best_query_pos (best_query_pos),
        .best_target_pos(best_target_pos),
        .truncated      (truncated)
    );

    always #2 clk = ~clk;

    // Scoring state kept alongside the block.
    logic [SYM_W-1:0] query_sym [QUERY_CAP];
    int               column [QUERY_CAP];
    int               query_len = 0;
    bit               query_done = 1'b1;
    bit               query_dropped = 1'b0;
    int               top_score, top_qpos, top_tpos, tgt_pos;
    int               match_gain = int'(MATCH_RST);
    int               mismatch_val = $signed(MISMATCH_RST);
    int               gap_val = $signed(GAP_RST);
    alignment_t       expected_alignments [$];

    int               errors = 0;
    int               beats_sent = 0;
    int               send_gap_max = 15;
    int               recv_stall_max = 15;
    int               stall_left = 0;
    int               sym_base = 0;
    bit               sym_wide = 1'b0;
    alignment_t       want;

    function automatic void clear_target_state();
        foreach (column[i])
            column[i] = 0;
        top_score = 0;
        top_qpos = 0;
        top_tpos = 0;
        tgt_pos = 0;
    endfunction

    function automatic void advance_alignment(logic c, logic [SYM_W-1:0] s, logic l);
        int diag, up, left, h, d, u, lf;
        alignment_t r;
        if (c == CMD_LOAD) begin
            if (query_done) begin
                query_len = 0;
                query_dropped = 1'b0;
                query_done = 1'b0;
                clear_target_state();
            end
            if (query_len < QUERY_CAP) begin
                query_sym[query_len] = s;
                query_len++;
            end
            else begin
                query_dropped = 1'b1;
            end
            if (l)
                query_done = 1'b1;
        end
        else begin
            query_done = 1'b1;
            if (tgt_pos < TPOS_TOP)
                tgt_pos++;
            diag = 0;
            up = 0;
            for (int i = 0; i < query_len; i++) begin
                left = column[i];
                d = diag + ((query_sym[i] == s) ? match_gain : mismatch_val);
                u = up + gap_val;
                lf = left + gap_val;
                h = d;
                if (u > h)
                    h = u;
                if (lf > h)
                    h = lf;
                if (h < 0)
                    h = 0;
                if (h > int'(SCORE_MAX))
                    h = int'(SCORE_MAX);
                column[i] = h;
                diag = left;
                up = h;
                // Ties go to the later cell in query-major order.
                if (h > 0 && (h > top_score || (h == top_score && i + 1 >= top_qpos))) begin
                    top_score = h;
                    top_qpos = i + 1;
                    top_tpos = tgt_pos;
                end
            end
            if (l) begin
                r.score = top_score[SCORE_W-1:0];
                r.qpos = top_qpos[QPOS_BITS-1:0];
                r.tpos = top_tpos[TPOS_W-1:0];
                r.trunc = query_dropped;
                expected_alignments.push_back(r);
                clear_target_state();
            end
        end
    endfunction

    task automatic send_beat(logic c, logic [SYM_W-1:0] s, logic l);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        cmd <= c;
        symbol <= s;
        last <= l;
        do
            @(posedge clk);
        while (item_stall);
        beats_sent++;
        advance_alignment(c, s, l);
    endtask

    // Drops valid and lets every beat leave the cell chain.
    task automatic settle();
        item_valid <= 1'b0;
        while (expected_alignments.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(int m, int mm, int g);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MATCH;
        cfg_data <= m[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_MISMATCH;
        cfg_data <= mm[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_GAP;
        cfg_data <= g[CFG_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        match_gain = m;
        mismatch_val = mm;
        gap_val = g;
    endtask

    function automatic int pick_extreme(int lo, int hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    // A narrow alphabet gives frequent matches; the wide one covers every code.
    task automatic pick_alphabet();
        sym_wide = ($urandom_range(0, 3) == 0);
        sym_base = $urandom_range(0, 252);
    endtask

    function automatic logic [SYM_W-1:0] draw_symbol();
        if (sym_wide)
            return SYM_W'($urandom);
        return SYM_W'(sym_base + int'($urandom_range(0, 3)));
    endfunction

    task automatic send_query(int len, bit close);
        for (int k = 0; k < len; k++)
            send_beat(CMD_LOAD, draw_symbol(), close && k == len - 1);
    endtask

    task automatic send_target(int len, bit close);
        for (int k = 0; k < len; k++)
            send_beat(CMD_TARGET, draw_symbol(), close && k == len - 1);
    endtask

    task automatic run_sequences(int n_beats);
        int start, kind, qlen;
        start = beats_sent;
        while (beats_sent - start < n_beats) begin
            kind = $urandom_range(0, 99);
            pick_alphabet();
            if (kind < 70) begin
                if ($urandom_range(0, 19) == 0)
                    qlen = $urandom_range(17, QUERY_CAP + 8);
                else
                    qlen = $urandom_range(1, 16);
                send_query(qlen, 1'b1);
                repeat ($urandom_range(1, 2))
                    send_target($urandom_range(1, 24), 1'b1);
            end
            else if (kind < 80) begin
                send_query($urandom_range(1, 12), 1'b0);
                send_target($urandom_range(1, 16), 1'b1);
            end
            else if (kind < 90) begin
                // A target cut short by a new query.
                send_target($urandom_range(1, 8), 1'b0);
                send_query($urandom_range(1, 8), 1'b1);
                send_target($urandom_range(1, 8), 1'b1);
            end
            else begin
                repeat ($urandom_range(1, 6))
                    send_beat(1'($urandom), SYM_W'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_empty_query();
        send_beat(CMD_TARGET, 8'h41, 1'b0);
        send_beat(CMD_TARGET, 8'h42, 1'b1);
    endtask

    task automatic test_scoring_cases();
        send_beat(CMD_LOAD, 8'h41, 1'b0);
        send_beat(CMD_LOAD, 8'h43, 1'b0);
        send_beat(CMD_LOAD, 8'h47, 1'b1);
        send_beat(CMD_TARGET, 8'h41, 1'b0);
        send_beat(CMD_TARGET, 8'h43, 1'b0);
        send_beat(CMD_TARGET, 8'h47, 1'b1);
        // Two equal cells in one column: the higher query position wins.
        send_beat(CMD_LOAD, 8'h41, 1'b0);
        send_beat(CMD_LOAD, 8'h41, 1'b1);
        send_beat(CMD_TARGET, 8'h41, 1'b1);
        // No positive cell at all.
        send_beat(CMD_LOAD, 8'h41, 1'b1);
        send_beat(CMD_TARGET, 8'h43, 1'b1);
        // The query is never marked; streaming closes it.
        send_beat(CMD_LOAD, 8'h41, 1'b0);
        send_beat(CMD_LOAD, 8'h42, 1'b0);
        send_beat(CMD_TARGET, 8'h41, 1'b0);
        send_beat(CMD_TARGET, 8'h42, 1'b1);
        send_beat(CMD_LOAD, 8'h43, 1'b1);
        send_beat(CMD_TARGET, 8'h43, 1'b1);
        send_beat(CMD_TARGET, 8'h41, 1'b0);
        send_beat(CMD_LOAD, 8'h41, 1'b1);
        send_beat(CMD_TARGET, 8'h41, 1'b1);
        send_beat(CMD_LOAD, 8'h00, 1'b0);
        send_beat(CMD_LOAD, 8'hFF, 1'b1);
        send_beat(CMD_TARGET, 8'hFF, 1'b0);
        send_beat(CMD_TARGET, 8'h00, 1'b1);
    endtask

    task automatic test_config_settings();
        int m_set [5] = '{15, 0, 15, 0, 7};
        int mm_set [5] = '{-15, 0, 0, -15, -1};
        int g_set [5] = '{-15, 0, 0, -15, -15};
        for (int k = 0; k < 5; k++) begin
            settle();
            write_config(m_set[k], mm_set[k], g_set[k]);
            run_sequences(60);
        end
    endtask

    task automatic test_query_overflow();
        pick_alphabet();
        send_query(QUERY_CAP + 20, 1'b1);
        send_target(8, 1'b1);
        // The flag holds for every target until a new query starts.
        send_target(5, 1'b1);
        send_query(QUERY_CAP + 3, 1'b0);
        send_target(6, 1'b1);
        send_query(4, 1'b1);
        send_target(4, 1'b1);
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < 5; seg++) begin
            settle();
            write_config(pick_extreme(0, 15), pick_extreme(-15, 0), pick_extreme(-15, 0));
            send_gap_max = (seg == 2) ? 0 : 15;
            recv_stall_max = (seg == 2) ? 0 : 15;
            run_sequences(220);
        end
        send_gap_max = 15;
        recv_stall_max = 15;
    endtask

    task automatic report_field(string field, int exp_val, int act_val);
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, act_val);
    endtask

    // Result side: random stall, counted down only while a result is offered.
    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            if (expected_alignments.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, score %0d qpos %0d tpos %0d trunc %0d",
                         $time, best_score, best_query_pos, best_target_pos, truncated);
            end
            else begin
                want = expected_alignments.pop_front();
                if (best_score !== want.score)
                    report_field("best_score", int'(want.score), int'(best_score));
                if (best_query_pos !== want.qpos)
                    report_field("best_query_pos", int'(want.qpos), int'(best_query_pos));
                if (best_target_pos !== want.tpos)
                    report_field("best_target_pos", int'(want.tpos), int'(best_target_pos));
                if (truncated !== want.trunc)
                    report_field("truncated", int'(want.trunc), int'(truncated));
            end
            stall_left = $urandom_range(0, recv_stall_max);
        end
        else if (result_valid && stall_left != 0) begin
            stall_left--;
        end
        result_stall <= (stall_left != 0);
    end

    initial begin
        clear_target_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_query();
        test_scoring_cases();
        test_config_settings();
        test_query_overflow();
        test_random_traffic();
        settle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/las_pkg.sv
rtl/core/las_cell.sv
rtl/core/local_alignment_score.sv
tb/tb.sv
